@@ rtl/ksc_pkg.sv @@
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared types, codes and letter decoding for the keyword substitution cipher.
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int ALPHA_COUNT = 26;
  localparam int IDX_W       = $clog2(ALPHA_COUNT);

  localparam logic [7:0] LOWER_BASE = 8'h61;
  localparam logic [7:0] UPPER_BASE = 8'h41;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHA_COUNT - 1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_KEY      = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_ENCRYPT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_IGNORED    = 2'd1,
    ST_NOT_READY  = 2'd2,
    ST_NON_LETTER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ
  } state_t;

  typedef struct packed {
    logic is_letter;
    logic upper;
    idx_t idx;
  } letter_t;

  function automatic letter_t decode_letter(input logic [7:0] b);
    letter_t r;
    r = '0;
    if (b >= LOWER_BASE && b < LOWER_BASE + 8'(ALPHA_COUNT)) begin
      r.is_letter = 1'b1;
      r.idx       = IDX_W'(b - LOWER_BASE);
    end else if (b >= UPPER_BASE && b < UPPER_BASE + 8'(ALPHA_COUNT)) begin
      r.is_letter = 1'b1;
      r.upper     = 1'b1;
      r.idx       = IDX_W'(b - UPPER_BASE);
    end
    return r;
  endfunction

endpackage

@@ rtl/ksc_if.sv @@
// ----------------------------------------------------------------------------
// ksc_in_if / ksc_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface ksc_in_if;
  import ksc_pkg::*;

  logic       valid;
  logic       ready;
  opcode_t    opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface ksc_out_if;
  import ksc_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  status_t    status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
endinterface

@@ rtl/keyword_substitution_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_unit
// Builds a 26-letter substitution alphabet from a keyword and enciphers bytes.
// ----------------------------------------------------------------------------
// Usage:
//   feed   : request transactions (opcode, data_byte), valid/ready.
//   result : one result transaction (out_byte, status) per request.
//   The substitution table sits in a 26 x 5 synchronous memory. Requests are
//   taken one at a time: feed.ready is high when the unit is idle and the
//   output register is empty or being drained in the same cycle.
//   Clear, keyword byte, complete on a ready table and passthrough load the
//   output register directly on acceptance. An encrypt of a letter on a ready
//   table first reads the memory (S_READ), then loads the result. Complete on
//   a table not yet ready sweeps all 26 letters through the single memory
//   write port, one letter a cycle (S_FILL), then loads its result.
//   Encryption takes no new byte while the memory read of the last is pending.
//   Reset clears the used-letter mask, fill count, ready flag and output
//   valid flag; the table memory is not cleared and is only read once all
//   26 entries have been written.
//   While the sink stalls, the result is held and no new request is taken.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_unit (
  input  logic      clk,
  input  logic      rst,
  ksc_in_if.sink    feed,
  ksc_out_if.source result
);
  import ksc_pkg::*;

  logic [IDX_W-1:0] letter_map [ALPHA_COUNT];
  idx_t             rd_data;

  state_t                 state, state_next;
  logic [ALPHA_COUNT-1:0] used, used_next;
  idx_t                   fill, fill_next;
  logic                   ready, ready_next;
  idx_t                   sweep, sweep_next;
  logic                   upper, upper_next;

  logic       out_valid;
  logic [7:0] out_byte;
  status_t    out_status;

  logic       accept;
  letter_t    dec;
  logic       mem_we;
  idx_t       mem_waddr;
  idx_t       mem_wdata;
  logic       rd_en;
  logic       load;
  logic [7:0] load_byte;
  status_t    load_status;

  assign dec           = decode_letter(feed.data_byte);
  assign feed.ready    = (state == S_IDLE) && (!out_valid || result.ready);
  assign accept        = feed.valid && feed.ready;
  assign result.valid  = out_valid;
  assign result.out_byte = out_byte;
  assign result.status = out_status;

  always_comb begin
    state_next  = state;
    used_next   = used;
    fill_next   = fill;
    ready_next  = ready;
    sweep_next  = sweep;
    upper_next  = upper;
    mem_we      = 1'b0;
    mem_waddr   = fill;
    mem_wdata   = '0;
    rd_en       = 1'b0;
    load        = 1'b0;
    load_byte   = '0;
    load_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (feed.opcode)
            OP_CLEAR: begin
              used_next  = '0;
              fill_next  = '0;
              ready_next = 1'b0;
              load       = 1'b1;
            end
            OP_KEY: begin
              load = 1'b1;
              if (ready || !dec.is_letter || used[dec.idx]) begin
                load_status = ST_IGNORED;
              end else begin
                mem_we             = 1'b1;
                mem_wdata          = dec.idx;
                fill_next          = fill + 1'b1;
                used_next[dec.idx] = 1'b1;
              end
            end
            OP_COMPLETE: begin
              if (ready) begin
                load = 1'b1;
              end else begin
                sweep_next = '0;
                state_next = S_FILL;
              end
            end
            OP_ENCRYPT: begin
              if (!ready) begin
                load        = 1'b1;
                load_byte   = feed.data_byte;
                load_status = ST_NOT_READY;
              end else if (!dec.is_letter) begin
                load        = 1'b1;
                load_byte   = feed.data_byte;
                load_status = ST_NON_LETTER;
              end else begin
                rd_en      = 1'b1;
                upper_next = dec.upper;
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        // place each unused letter in alphabet order
        if (!used[sweep]) begin
          mem_we           = 1'b1;
          mem_wdata        = sweep;
          fill_next        = fill + 1'b1;
          used_next[sweep] = 1'b1;
        end
        if (sweep == LAST_IDX) begin
          ready_next = 1'b1;
          load       = 1'b1;
          state_next = S_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      S_READ: begin
        load       = 1'b1;
        load_byte  = (upper ? UPPER_BASE : LOWER_BASE) + {{(8-IDX_W){1'b0}}, rd_data};
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      fill  <= '0;
      ready <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      fill  <= fill_next;
      ready <= ready_next;
    end
  end

  always_ff @(posedge clk) begin
    sweep <= sweep_next;
    upper <= upper_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      letter_map[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= letter_map[dec.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= load_byte;
      out_status <= load_status;
    end
  end

endmodule

@@ rtl/ksc_checker.sv @@
// ----------------------------------------------------------------------------
// ksc_checker
// Port-level checks on the keyword substitution cipher unit.
// ----------------------------------------------------------------------------
module ksc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_status
);
  import ksc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status))
    else $error("stalled result changed");

  // take a transaction only with room for its result
  a_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("request taken with result pending");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_opcode == OP_CLEAR |=>
      out_valid && out_byte == 8'd0 && out_status == ST_OK)
    else $error("bad clear result");

  a_key: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_opcode == OP_KEY |=>
      out_valid && out_byte == 8'd0 && (out_status == ST_OK || out_status == ST_IGNORED))
    else $error("bad keyword result");

endmodule

bind keyword_substitution_cipher_unit ksc_checker u_ksc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (feed.valid),
  .in_ready   (feed.ready),
  .in_opcode  (feed.opcode),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_byte   (result.out_byte),
  .out_status (result.status)
);
